>>> hdl/ghst_pkg.sv
// ----------------------------------------------------------------------------
// ghst_pkg
// Shared constants of the generational slot handle table: operation and
// status codes, handle layout and default sizes.
// ----------------------------------------------------------------------------
package ghst_pkg;

    localparam int SLOT_COUNT_DEF   = 16;
    localparam int SERIAL_WIDTH_DEF = 8;

    localparam int OP_W            = 3;
    localparam int STATUS_W        = 3;
    localparam int OWNER_W         = 16;
    localparam int HANDLE_W        = 32;
    localparam int HANDLE_INDEX_W  = 16;
    localparam int HANDLE_SERIAL_W = 15;

    localparam logic [OP_W-1:0] OP_CREATE    = 3'd0;
    localparam logic [OP_W-1:0] OP_KILL      = 3'd1;
    localparam logic [OP_W-1:0] OP_SCAN_ALL  = 3'd2;
    localparam logic [OP_W-1:0] OP_SCAN_OWNER = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NEGATIVE  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_LIVE  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_MISMATCH  = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_NONE      = 3'd5;
    localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 3'd6;

endpackage

>>> hdl/ghst_slot_mem.sv
// ----------------------------------------------------------------------------
// ghst_slot_mem
// Slot store holding the stamped serial and owner of each slot. One write
// port and one read port; read data is registered and holds between reads.
// ----------------------------------------------------------------------------
module ghst_slot_mem #(
    parameter int DEPTH  = ghst_pkg::SLOT_COUNT_DEF,
    parameter int ADDR_W = $clog2(ghst_pkg::SLOT_COUNT_DEF),
    parameter int DATA_W = ghst_pkg::SERIAL_WIDTH_DEF + ghst_pkg::OWNER_W
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/generational_slot_handle_table_core.sv
// ----------------------------------------------------------------------------
// generational_slot_handle_table_core
// Slot table that hands out generation-stamped handles, kills them, scans
// the live slots and clears the table.
//
//   Channel  Signals                                   Direction
//   in       in_valid, in_ready, op, handle, owner     into the block
//   out      out_valid, out_ready, status,             out of the block
//            result_handle, slot_index, slot_serial,
//            first_of_run, last
//
// Create searches the live bits in order for the first free slot. Kill
// reads the slot store to compare the stored serial; a negative or
// out-of-range handle skips the read. Scans issue one slot store read per
// cycle while no stalled output word holds them.
// Reset clears the live bits and the serial counter; the slot store needs
// no clearing. A stalled output word holds the scan pipeline in place.
// ----------------------------------------------------------------------------
module generational_slot_handle_table_core #(
    parameter int SLOT_COUNT   = ghst_pkg::SLOT_COUNT_DEF,
    parameter int SERIAL_WIDTH = ghst_pkg::SERIAL_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [ghst_pkg::OP_W-1:0]               op,
    input  logic signed [ghst_pkg::HANDLE_W-1:0]    handle,
    input  logic signed [ghst_pkg::OWNER_W-1:0]     owner,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [ghst_pkg::STATUS_W-1:0]           status,
    output logic signed [SERIAL_WIDTH+ghst_pkg::HANDLE_INDEX_W:0] result_handle,
    output logic [$clog2(SLOT_COUNT)-1:0]           slot_index,
    output logic [SERIAL_WIDTH-1:0]                 slot_serial,
    output logic                                    first_of_run,
    output logic                                    last
);

    localparam int IDX_W  = $clog2(SLOT_COUNT);
    localparam int CNT_W  = IDX_W + 1;
    localparam int RH_W   = SERIAL_WIDTH + ghst_pkg::HANDLE_INDEX_W + 1;
    localparam int DATA_W = SERIAL_WIDTH + ghst_pkg::OWNER_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CREATE = 5'b00010,
        S_KILL   = 5'b00100,
        S_SCAN   = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [SLOT_COUNT-1:0]   live_reg, live_next;
    logic [SERIAL_WIDTH-1:0] serial_reg, serial_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    scan_all_reg, scan_all_next;
    logic [ghst_pkg::OWNER_W-1:0] owner_reg, owner_next;
    logic [IDX_W-1:0]        kidx_reg, kidx_next;
    logic [ghst_pkg::HANDLE_SERIAL_W-1:0] hser_reg, hser_next;
    logic                    rdv_reg, rdv_next;
    logic [IDX_W-1:0]        rdidx_reg, rdidx_next;
    logic                    pend_reg, pend_next;
    logic                    found_reg, found_next;

    logic [ghst_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [RH_W-1:0]         res_handle_reg, res_handle_next;
    logic [IDX_W-1:0]        res_idx_reg, res_idx_next;
    logic [SERIAL_WIDTH-1:0] res_serial_reg, res_serial_next;
    logic                    res_first_reg, res_first_next;

    logic                    out_valid_reg, out_valid_next;
    logic [ghst_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [RH_W-1:0]         out_handle_reg, out_handle_next;
    logic [IDX_W-1:0]        out_idx_reg, out_idx_next;
    logic [SERIAL_WIDTH-1:0] out_serial_reg, out_serial_next;
    logic                    out_first_reg, out_first_next;
    logic                    out_last_reg, out_last_next;

    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [DATA_W-1:0]       wr_data;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic [DATA_W-1:0]       rd_data;

    logic [SERIAL_WIDTH-1:0]      mem_serial;
    logic [ghst_pkg::OWNER_W-1:0] mem_owner;
    logic                    out_free;
    logic                    accept;
    logic [IDX_W-1:0]        cnt_idx;
    logic                    issue_ok;
    logic                    match;
    logic                    stall;
    logic [SERIAL_WIDTH-1:0] serial_inc;
    logic                    bad_index;

    ghst_slot_mem #(
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (IDX_W),
        .DATA_W (DATA_W)
    ) u_slot_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign mem_serial = rd_data[DATA_W-1:ghst_pkg::OWNER_W];
    assign mem_owner  = rd_data[ghst_pkg::OWNER_W-1:0];
    assign out_free   = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign cnt_idx    = cnt_reg[IDX_W-1:0];
    assign issue_ok   = (cnt_reg != CNT_W'(SLOT_COUNT));
    assign serial_inc = serial_reg + 1'b1;
    assign bad_index  = ({1'b0, handle[ghst_pkg::HANDLE_INDEX_W-1:0]}
                         >= (ghst_pkg::HANDLE_INDEX_W + 1)'(SLOT_COUNT));
    assign match      = rdv_reg && live_reg[rdidx_reg]
                        && (scan_all_reg || (mem_owner == owner_reg));
    assign stall      = match && pend_reg && !out_free;

    always_comb
    begin
        state_next      = state_reg;
        live_next       = live_reg;
        serial_next     = serial_reg;
        cnt_next        = cnt_reg;
        scan_all_next   = scan_all_reg;
        owner_next      = owner_reg;
        kidx_next       = kidx_reg;
        hser_next       = hser_reg;
        rdv_next        = rdv_reg;
        rdidx_next      = rdidx_reg;
        pend_next       = pend_reg;
        found_next      = found_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_idx_next    = res_idx_reg;
        res_serial_next = res_serial_reg;
        res_first_next  = res_first_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_handle_next = out_handle_reg;
        out_idx_next    = out_idx_reg;
        out_serial_next = out_serial_reg;
        out_first_next  = out_first_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        wr_addr         = cnt_idx;
        wr_data         = {serial_inc, owner_reg};
        rd_en           = 1'b0;
        rd_addr         = cnt_idx;

        case (state_reg)
            S_IDLE:
            begin
                res_handle_next = '0;
                res_idx_next    = '0;
                res_serial_next = '0;
                res_first_next  = 1'b0;
                rd_addr         = handle[IDX_W-1:0];
                if (accept)
                begin
                    owner_next = owner;
                    cnt_next   = '0;
                    case (op)
                        ghst_pkg::OP_CREATE:
                        begin
                            state_next = S_CREATE;
                        end
                        ghst_pkg::OP_KILL:
                        begin
                            if (handle[ghst_pkg::HANDLE_W-1])
                            begin
                                res_status_next = ghst_pkg::STATUS_NEGATIVE;
                                state_next      = S_EMIT;
                            end
                            else if (bad_index)
                            begin
                                res_status_next = ghst_pkg::STATUS_BAD_INDEX;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                kidx_next  = handle[IDX_W-1:0];
                                hser_next  = handle[ghst_pkg::HANDLE_W-2:
                                                    ghst_pkg::HANDLE_INDEX_W];
                                state_next = S_KILL;
                            end
                        end
                        ghst_pkg::OP_SCAN_ALL, ghst_pkg::OP_SCAN_OWNER:
                        begin
                            scan_all_next = (op == ghst_pkg::OP_SCAN_ALL);
                            rdv_next      = 1'b0;
                            pend_next     = 1'b0;
                            found_next    = 1'b0;
                            state_next    = S_SCAN;
                        end
                        ghst_pkg::OP_CLEAR:
                        begin
                            live_next       = '0;
                            res_status_next = ghst_pkg::STATUS_OK;
                            state_next      = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_CREATE:
            begin
                if (!issue_ok)
                begin
                    res_status_next = ghst_pkg::STATUS_FULL;
                    res_handle_next = '1;
                    res_idx_next    = '0;
                    res_serial_next = '0;
                    state_next      = S_EMIT;
                end
                else if (!live_reg[cnt_idx])
                begin
                    wr_en              = 1'b1;
                    live_next[cnt_idx] = 1'b1;
                    serial_next        = serial_inc;
                    res_status_next    = ghst_pkg::STATUS_OK;
                    res_handle_next    = {1'b0, serial_inc,
                                          ghst_pkg::HANDLE_INDEX_W'(cnt_idx)};
                    res_idx_next       = cnt_idx;
                    res_serial_next    = serial_inc;
                    state_next         = S_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_KILL:
            begin
                res_idx_next = kidx_reg;
                if (!live_reg[kidx_reg])
                begin
                    res_status_next = ghst_pkg::STATUS_NOT_LIVE;
                    res_serial_next = '0;
                end
                else if (ghst_pkg::HANDLE_SERIAL_W'(mem_serial) != hser_reg)
                begin
                    res_status_next = ghst_pkg::STATUS_MISMATCH;
                    res_serial_next = mem_serial;
                end
                else
                begin
                    res_status_next     = ghst_pkg::STATUS_OK;
                    res_serial_next     = mem_serial;
                    live_next[kidx_reg] = 1'b0;
                end
                state_next = S_EMIT;
            end

            S_SCAN:
            begin
                if (!stall)
                begin
                    if (issue_ok)
                    begin
                        rd_en      = 1'b1;
                        cnt_next   = cnt_reg + 1'b1;
                        rdv_next   = 1'b1;
                        rdidx_next = cnt_idx;
                    end
                    else
                    begin
                        rdv_next = 1'b0;
                    end
                    if (match)
                    begin
                        if (pend_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = ghst_pkg::STATUS_OK;
                            out_handle_next = '0;
                            out_idx_next    = res_idx_reg;
                            out_serial_next = res_serial_reg;
                            out_first_next  = res_first_reg;
                            out_last_next   = 1'b0;
                        end
                        pend_next       = 1'b1;
                        found_next      = 1'b1;
                        res_status_next = ghst_pkg::STATUS_OK;
                        res_handle_next = '0;
                        res_idx_next    = rdidx_reg;
                        res_serial_next = mem_serial;
                        res_first_next  = !found_reg;
                    end
                    if (!rdv_reg && !issue_ok)
                    begin
                        if (!pend_reg)
                        begin
                            res_status_next = ghst_pkg::STATUS_NONE;
                        end
                        state_next = S_EMIT;
                    end
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_handle_next = res_handle_reg;
                    out_idx_next    = res_idx_reg;
                    out_serial_next = res_serial_reg;
                    out_first_next  = res_first_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            live_reg      <= '0;
            serial_reg    <= '0;
            rdv_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            live_reg      <= live_next;
            serial_reg    <= serial_next;
            rdv_reg       <= rdv_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        scan_all_reg   <= scan_all_next;
        owner_reg      <= owner_next;
        kidx_reg       <= kidx_next;
        hser_reg       <= hser_next;
        rdidx_reg      <= rdidx_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_idx_reg    <= res_idx_next;
        res_serial_reg <= res_serial_next;
        res_first_reg  <= res_first_next;
        out_status_reg <= out_status_next;
        out_handle_reg <= out_handle_next;
        out_idx_reg    <= out_idx_next;
        out_serial_reg <= out_serial_next;
        out_first_reg  <= out_first_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign result_handle = out_handle_reg;
    assign slot_index    = out_idx_reg;
    assign slot_serial   = out_serial_reg;
    assign first_of_run  = out_first_reg;
    assign last          = out_last_reg;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the generational slot handle table. A short table
// of directed words covers the field extremes, every operation and every
// status. Random traffic follows, weighted toward well-formed kills of live
// handles, and closes with a stretch that runs without idling. Each accepted
// word is run through a local model of the table, and every result word is
// compared field by field.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SLOTS        = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_END   = 260;
    localparam int ITEM_TOTAL   = 320;

    localparam logic [ghst_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [ghst_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [ghst_pkg::STATUS_W-1:0] status;
        logic [24:0]                   result_handle;
        logic [3:0]                    slot_index;
        logic [7:0]                    slot_serial;
        logic                          first_of_run;
        logic                          last;
    } table_word_t;

    typedef struct {
        logic [ghst_pkg::OP_W-1:0] op;
        logic [31:0]               handle;
        logic [15:0]               owner;
        int                        reps;
        bit                        typed;
        table_word_t               want;
    } stim_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [ghst_pkg::OP_W-1:0]     op;
    logic signed [31:0]            handle;
    logic signed [15:0]            owner;
    logic                          out_valid;
    logic                          out_ready;
    logic [ghst_pkg::STATUS_W-1:0] status;
    logic signed [24:0]            result_handle;
    logic [3:0]                    slot_index;
    logic [7:0]                    slot_serial;
    logic                          first_of_run;
    logic                          last;

    bit          slot_live [SLOTS];
    logic [7:0]  slot_serial_of [SLOTS];
    logic [15:0] slot_owner_of [SLOTS];
    logic [7:0]  serial_count;
    bit          serial_wrapped;

    table_word_t expected_words [$];
    stim_row_t   stim_rows [$];

    int errors;
    int words_sent;
    int random_items;
    int words_checked;
    int status_seen [8];
    bit quiet;
    bit held;

    generational_slot_handle_table_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .handle        (handle),
        .owner         (owner),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .result_handle (result_handle),
        .slot_index    (slot_index),
        .slot_serial   (slot_serial),
        .first_of_run  (first_of_run),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic table_word_t make_word(input logic [ghst_pkg::STATUS_W-1:0] st,
                                              input logic [24:0] rh,
                                              input logic [3:0] ix,
                                              input logic [7:0] sr,
                                              input logic fr,
                                              input logic ls);
        table_word_t w;
        w.status        = st;
        w.result_handle = rh;
        w.slot_index    = ix;
        w.slot_serial   = sr;
        w.first_of_run  = fr;
        w.last          = ls;
        return w;
    endfunction

    function automatic void clear_entry(input int s);
        slot_live[s]      = 1'b0;
        slot_serial_of[s] = '0;
        slot_owner_of[s]  = '0;
    endfunction

    function automatic void compute_table_response(input logic [ghst_pkg::OP_W-1:0] o,
                                                   input logic [31:0] h,
                                                   input logic [15:0] ow,
                                                   input bit push);
        table_word_t resp [$];
        table_word_t w;
        int          slot;
        int          hits;
        int          i;
        logic [15:0] ix;
        logic [3:0]  s4;
        slot = -1;
        hits = 0;
        ix   = h[15:0];
        s4   = ix[3:0];
        case (o)
            ghst_pkg::OP_CREATE:
            begin
                for (i = 0; i < SLOTS; i++)
                    if (!slot_live[i] && slot < 0)
                        slot = i;
                if (slot < 0)
                    resp.push_back(make_word(ghst_pkg::STATUS_FULL, '1, '0, '0,
                                             1'b0, 1'b1));
                else
                begin
                    serial_count = serial_count + 8'd1;
                    if (serial_count == '0)
                        serial_wrapped = 1'b1;
                    slot_live[slot]      = 1'b1;
                    slot_serial_of[slot] = serial_count;
                    slot_owner_of[slot]  = ow;
                    resp.push_back(make_word(ghst_pkg::STATUS_OK,
                                             {1'b0, serial_count, 16'(slot)},
                                             4'(slot), serial_count, 1'b0, 1'b1));
                end
            end
            ghst_pkg::OP_KILL:
            begin
                if (h[31])
                    resp.push_back(make_word(ghst_pkg::STATUS_NEGATIVE, '0, '0, '0,
                                             1'b0, 1'b1));
                else if (ix >= SLOTS)
                    resp.push_back(make_word(ghst_pkg::STATUS_BAD_INDEX, '0, '0, '0,
                                             1'b0, 1'b1));
                else if (!slot_live[s4])
                    resp.push_back(make_word(ghst_pkg::STATUS_NOT_LIVE, '0, s4,
                                             slot_serial_of[s4], 1'b0, 1'b1));
                else if (h[30:16] != {7'b0, slot_serial_of[s4]})
                    resp.push_back(make_word(ghst_pkg::STATUS_MISMATCH, '0, s4,
                                             slot_serial_of[s4], 1'b0, 1'b1));
                else
                begin
                    resp.push_back(make_word(ghst_pkg::STATUS_OK, '0, s4,
                                             slot_serial_of[s4], 1'b0, 1'b1));
                    clear_entry(s4);
                end
            end
            ghst_pkg::OP_SCAN_ALL, ghst_pkg::OP_SCAN_OWNER:
            begin
                for (i = 0; i < SLOTS; i++)
                begin
                    if (slot_live[i] && (o == ghst_pkg::OP_SCAN_ALL
                                         || slot_owner_of[i] == ow))
                    begin
                        resp.push_back(make_word(ghst_pkg::STATUS_OK, '0, 4'(i),
                                                 slot_serial_of[i], hits == 0, 1'b0));
                        hits++;
                    end
                end
                if (hits == 0)
                    resp.push_back(make_word(ghst_pkg::STATUS_NONE, '0, '0, '0,
                                             1'b0, 1'b1));
                else
                begin
                    w = resp[hits-1];
                    w.last = 1'b1;
                    resp[hits-1] = w;
                end
            end
            ghst_pkg::OP_CLEAR:
            begin
                for (i = 0; i < SLOTS; i++)
                    clear_entry(i);
                resp.push_back(make_word(ghst_pkg::STATUS_OK, '0, '0, '0, 1'b0, 1'b1));
            end
            default:
            begin
            end
        endcase
        if (push)
            foreach (resp[k])
                expected_words.push_back(resp[k]);
    endfunction

    function automatic logic [31:0] pick_kill_handle();
        int          r;
        int          s;
        int          k;
        logic [14:0] ser;
        r = $urandom_range(0, 99);
        s = $urandom_range(0, SLOTS - 1);
        for (k = 0; k < SLOTS && !slot_live[s]; k++)
            s = (s + 1) % SLOTS;
        ser = {7'b0, slot_serial_of[s]};
        if (r < 55)
            return {1'b0, ser, 16'(s)};
        if (r < 75)
            return {1'b0, ser ^ (15'd1 << $urandom_range(0, 14)), 16'(s)};
        if (r < 85)
            return {1'b0, 15'($urandom), 16'($urandom_range(0, SLOTS - 1))};
        return $urandom;
    endfunction

    function automatic void add_row(input logic [ghst_pkg::OP_W-1:0] o,
                                    input logic [31:0] h,
                                    input logic [15:0] ow, input int reps,
                                    input bit typed, input table_word_t want);
        stim_row_t row;
        row.op     = o;
        row.handle = h;
        row.owner  = ow;
        row.reps   = reps;
        row.typed  = typed;
        row.want   = want;
        stim_rows.push_back(row);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with in_valid still high.
    task automatic send_word(input logic [ghst_pkg::OP_W-1:0] o, input logic [31:0] h,
                             input logic [15:0] ow, input bit typed,
                             input table_word_t want);
        in_valid <= 1'b1;
        op       <= o;
        handle   <= h;
        owner    <= ow;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
        compute_table_response(o, h, ow, !typed);
        if (typed)
            expected_words.push_back(want);
        @(negedge clk);
    endtask

    task automatic maybe_idle();
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
    endtask

    task automatic send_random();
        int                        r;
        logic [ghst_pkg::OP_W-1:0] o;
        logic [31:0]               h;
        logic [15:0]               ow;
        r = $urandom_range(0, 99);
        h = $urandom;
        case ($urandom_range(0, 5))
            0: ow = 16'h8000;
            1: ow = 16'h7FFF;
            2: ow = 16'h0001;
            3: ow = 16'hFFFF;
            default: ow = 16'($urandom);
        endcase
        if (r < 45)
            o = ghst_pkg::OP_CREATE;
        else if (r < 78)
        begin
            o = ghst_pkg::OP_KILL;
            h = pick_kill_handle();
        end
        else if (r < 86)
            o = ghst_pkg::OP_SCAN_ALL;
        else if (r < 94)
            o = ghst_pkg::OP_SCAN_OWNER;
        else if (r < 97)
            o = ghst_pkg::OP_CLEAR;
        else
            o = ghst_pkg::OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        send_word(o, h, ow, 1'b0, '0);
        if (o <= ghst_pkg::OP_CLEAR)
            random_items++;
    endtask

    task automatic check_field(input string name, input logic [24:0] want,
                               input logic [24:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    initial
    begin
        table_word_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                words_checked++;
                status_seen[status]++;
                if (expected_words.size() == 0)
                begin
                    $error("result word with no expectation, status %0d", status);
                    errors++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("status", want.status, status);
                    check_field("result_handle", want.result_handle, result_handle);
                    check_field("slot_index", want.slot_index, slot_index);
                    check_field("slot_serial", want.slot_serial, slot_serial);
                    check_field("first_of_run", want.first_of_run, first_of_run);
                    check_field("last", want.last, last);
                end
            end
        end
    end

    // The long hold-off lets the block back up and stall its input.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && words_checked >= 60)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_ready <= 1'b1;
            end
            else if (!quiet && rst_n && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("testbench failed");
        $finish;
    end

    initial
    begin
        int r;
        int n;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        op       = ghst_pkg::OP_CREATE;
        handle   = '0;
        owner    = '0;
        serial_count   = '0;
        serial_wrapped = 1'b0;
        for (r = 0; r < SLOTS; r++)
            clear_entry(r);

        add_row(ghst_pkg::OP_SCAN_ALL, 32'h0, 16'h0, 1, 1,
                make_word(ghst_pkg::STATUS_NONE, '0, '0, '0, 1'b0, 1'b1));
        add_row(ghst_pkg::OP_KILL, 32'h0000_0000, 16'h0, 1, 1,
                make_word(ghst_pkg::STATUS_NOT_LIVE, '0, 4'd0, 8'd0, 1'b0, 1'b1));
        add_row(ghst_pkg::OP_KILL, 32'h8000_0000, 16'h0, 1, 1,
                make_word(ghst_pkg::STATUS_NEGATIVE, '0, '0, '0, 1'b0, 1'b1));
        add_row(ghst_pkg::OP_KILL, 32'hFFFF_FFFF, 16'hFFFF, 1, 1,
                make_word(ghst_pkg::STATUS_NEGATIVE, '0, '0, '0, 1'b0, 1'b1));
        add_row(ghst_pkg::OP_KILL, 32'h7FFF_FFFF, 16'h0, 1, 1,
                make_word(ghst_pkg::STATUS_BAD_INDEX, '0, '0, '0, 1'b0, 1'b1));
        add_row(ghst_pkg::OP_KILL, 32'h0000_0010, 16'h0, 1, 1,
                make_word(ghst_pkg::STATUS_BAD_INDEX, '0, '0, '0, 1'b0, 1'b1));
        add_row(ghst_pkg::OP_CREATE, 32'h0, 16'h8000, 1, 1,
                make_word(ghst_pkg::STATUS_OK, 25'h001_0000, 4'd0, 8'd1, 1'b0, 1'b1));
        add_row(ghst_pkg::OP_CREATE, 32'h0, 16'h7FFF, 1, 1,
                make_word(ghst_pkg::STATUS_OK, 25'h002_0001, 4'd1, 8'd2, 1'b0, 1'b1));
        add_row(ghst_pkg::OP_KILL, 32'h0001_0000, 16'h0, 1, 1,
                make_word(ghst_pkg::STATUS_OK, '0, 4'd0, 8'd1, 1'b0, 1'b1));
        add_row(ghst_pkg::OP_KILL, 32'h0001_0000, 16'h0, 1, 1,
                make_word(ghst_pkg::STATUS_NOT_LIVE, '0, 4'd0, 8'd0, 1'b0, 1'b1));
        add_row(ghst_pkg::OP_KILL, 32'h0102_0001, 16'h0, 1, 1,
                make_word(ghst_pkg::STATUS_MISMATCH, '0, 4'd1, 8'd2, 1'b0, 1'b1));
        add_row(OP_UNUSED_LO, 32'hFFFF_FFFF, 16'hFFFF, 1, 0, '0);
        add_row(OP_UNUSED_HI, 32'h0, 16'h0, 1, 0, '0);
        add_row(ghst_pkg::OP_CREATE, 32'h0, 16'h0000, 15, 0, '0);
        add_row(ghst_pkg::OP_CREATE, 32'h0, 16'h0000, 1, 1,
                make_word(ghst_pkg::STATUS_FULL, '1, '0, '0, 1'b0, 1'b1));
        add_row(ghst_pkg::OP_SCAN_OWNER, 32'h0, 16'h7FFF, 1, 0, '0);
        add_row(ghst_pkg::OP_SCAN_ALL, 32'h0, 16'h0, 1, 0, '0);
        add_row(ghst_pkg::OP_SCAN_OWNER, 32'h0, 16'h1234, 1, 1,
                make_word(ghst_pkg::STATUS_NONE, '0, '0, '0, 1'b0, 1'b1));
        add_row(ghst_pkg::OP_KILL, 32'h7FFF_000F, 16'h0, 1, 0, '0);
        add_row(ghst_pkg::OP_CLEAR, 32'h0, 16'h0, 1, 1,
                make_word(ghst_pkg::STATUS_OK, '0, '0, '0, 1'b0, 1'b1));
        add_row(ghst_pkg::OP_SCAN_ALL, 32'h0, 16'h0, 1, 1,
                make_word(ghst_pkg::STATUS_NONE, '0, '0, '0, 1'b0, 1'b1));
        add_row(ghst_pkg::OP_KILL, 32'h0011_000F, 16'h0, 1, 1,
                make_word(ghst_pkg::STATUS_NOT_LIVE, '0, 4'd15, 8'd0, 1'b0, 1'b1));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (stim_rows[i])
        begin
            for (n = 0; n < stim_rows[i].reps; n++)
            begin
                send_word(stim_rows[i].op, stim_rows[i].handle, stim_rows[i].owner,
                          stim_rows[i].typed, stim_rows[i].want);
                maybe_idle();
            end
        end

        while (words_sent < RANDOM_END)
        begin
            send_random();
            maybe_idle();
        end
        quiet = 1'b1;
        while (words_sent < ITEM_TOTAL)
            send_random();
        in_valid <= 1'b0;

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d words, %0d of them random; checked %0d result words; %s",
                 words_sent, random_items, words_checked,
                 serial_wrapped ? "the serial counter wrapped." : "no serial wrap.");
        $display("Status counts ok/full/neg/dead/mismatch/none/bad: %0d %0d %0d %0d %0d %0d %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6]);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

>>> filelist.f
hdl/ghst_pkg.sv
hdl/ghst_slot_mem.sv
hdl/generational_slot_handle_table_core.sv
tb/testbench.sv
